// File: hdl/lnesc_pkg.sv
// Shared types and character codes for the line-number escaper.
// No dependencies; the files that use it refer to it by scoped names.
package lnesc_pkg;

  // Character codes used while expanding a byte
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_DASH     = 8'd45;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QMARK    = 8'd63;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_M        = 8'd77;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  // Mode bits as held by the top level
  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Fixed part of one queued job: optional number prefix plus 1..4 body bytes
  typedef struct packed {
    logic            has_num;
    logic [2:0]      body_len;
    logic [3:0][7:0] body;     // body[0] goes out first
  } job_t;

endpackage

// File: hdl/text_stream_line_number_escaper_top.sv
// Top level of the line-number escaper: config registers, front, queue, back.
// Depends on lnesc_pkg, lnesc_front, lnesc_fifo and lnesc_back.
//
// Text filter in the style of cat -b -n -s -E -T -v. Each input beat carries
// one text byte (tuser flags the first byte of a file) and yields zero to
// NUMBER_DIGITS+5 output beats; tlast marks the final beat of each input.
// An input beat is taken every cycle while the two-entry job queue has room,
// and the output register delivers one byte per cycle while the sink is ready,
// so plain text runs at one byte per clock; a byte that expands to N output
// bytes holds the output side until all are out; meanwhile the queue takes one
// further beat, then stalls input until the expansion's last byte is loaded.
// A squeezed blank line produces no output beat. The user must write the mode
// registers (cfg channel, always ready) only while the block is idle; unenforced.
module text_stream_line_number_escaper_top #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,     // bit 0 is the mode bit
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tuser_i,  // [0] starts_file
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o   // last_of_run
);

  localparam int JOB_W = $bits(lnesc_pkg::job_t) + 5 * NUMBER_DIGITS;

  lnesc_pkg::cfg_t               cfg_q;
  lnesc_pkg::job_t               f_job, b_job;
  logic [NUMBER_DIGITS-1:0][3:0] f_bcd, b_bcd;
  logic [NUMBER_DIGITS-1:0]      f_blank, b_blank;
  logic                          push, full, pop, q_valid;
  logic [JOB_W-1:0]              q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // Mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (lnesc_pkg::cfg_idx_e'(cfg_index_i))
        lnesc_pkg::CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data_i[0];
        lnesc_pkg::CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data_i[0];
        lnesc_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
        lnesc_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
        lnesc_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
        lnesc_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lnesc_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .starts_file_i(s_axis_tuser_i),
    .push_o       (push),
    .full_i       (full),
    .job_o        (f_job),
    .bcd_o        (f_bcd),
    .blank_o      (f_blank)
  );

  assign q_wdata = {f_bcd, f_blank, f_job};
  assign {b_bcd, b_blank, b_job} = q_rdata;

  lnesc_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  lnesc_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (b_job),
    .bcd_i      (b_bcd),
    .blank_i    (b_blank),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

// File: hdl/lnesc_front.sv
// Front end: accepts input beats, tracks line state and builds one job per kept byte.
// Depends on lnesc_pkg.
module lnesc_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lnesc_pkg::cfg_t                 cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            starts_file_i,
  output logic                            push_o,
  input  logic                            full_i,
  output lnesc_pkg::job_t                 job_o,
  output logic [NUMBER_DIGITS-1:0][3:0]   bcd_o,
  output logic [NUMBER_DIGITS-1:0]        blank_o
);

  logic [7:0]                     prev_q, prev_d;
  logic [1:0]                     run_q, run_d;
  logic [NUMBER_DIGITS-1:0][3:0]  cnt_q, cnt_d;
  logic [NUMBER_DIGITS-1:0][3:0]  cnt_inc;
  logic                           accept, at_ls, drop, all_nines, carry, seen;
  logic                           has_num;
  logic [1:0]                     run_start;
  logic [6:0]                     low;
  logic [1:0][7:0]                esc;
  logic [1:0]                     esc_len;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign at_ls      = (prev_q == lnesc_pkg::CH_NL);

  // Squeeze bookkeeping; a file start clears the blank run first
  always_comb begin
    run_start = starts_file_i ? 2'd0 : run_q;
    drop      = 1'b0;
    run_d     = 2'd0;
    if (cfg_i.squeeze_blank && in_byte_i == lnesc_pkg::CH_NL && at_ls) begin
      run_d = (run_start < 2'd2) ? run_start + 2'd1 : run_start;
      drop  = (run_d > 2'd1);
    end
  end

  // Decide on the number prefix
  always_comb begin
    if (cfg_i.number_nonblank) begin
      has_num = (in_byte_i != lnesc_pkg::CH_NL) && at_ls;
    end else begin
      has_num = cfg_i.number_all && at_ls;
    end
  end

  // Escape of the low seven bits
  always_comb begin
    low     = in_byte_i[6:0];
    esc     = '0;
    esc_len = 2'd1;
    if (low < 7'd32) begin
      esc[0]  = lnesc_pkg::CH_CARET;
      esc[1]  = {1'b0, low} + lnesc_pkg::CTRL_OFFSET;
      esc_len = 2'd2;
    end else if ({1'b0, low} == lnesc_pkg::CH_DEL) begin
      esc[0]  = lnesc_pkg::CH_CARET;
      esc[1]  = lnesc_pkg::CH_QMARK;
      esc_len = 2'd2;
    end else begin
      esc[0] = {1'b0, low};
    end
  end

  // Build the body bytes
  always_comb begin
    job_o.has_num  = has_num;
    job_o.body     = '0;
    job_o.body_len = 3'd1;
    if (cfg_i.show_ends && in_byte_i == lnesc_pkg::CH_NL) begin
      job_o.body[0]  = lnesc_pkg::CH_DOLLAR;
      job_o.body[1]  = lnesc_pkg::CH_NL;
      job_o.body_len = 3'd2;
    end else if (cfg_i.show_tabs && in_byte_i == lnesc_pkg::CH_TAB) begin
      job_o.body[0]  = lnesc_pkg::CH_CARET;
      job_o.body[1]  = lnesc_pkg::CH_I;
      job_o.body_len = 3'd2;
    end else if (cfg_i.show_nonprinting && in_byte_i != lnesc_pkg::CH_TAB &&
                 in_byte_i != lnesc_pkg::CH_NL) begin
      if (in_byte_i[7]) begin
        job_o.body[0]  = lnesc_pkg::CH_M;
        job_o.body[1]  = lnesc_pkg::CH_DASH;
        job_o.body[2]  = esc[0];
        job_o.body[3]  = esc[1];
        job_o.body_len = 3'd2 + {1'b0, esc_len};
      end else begin
        job_o.body[0]  = esc[0];
        job_o.body[1]  = esc[1];
        job_o.body_len = {1'b0, esc_len};
      end
    end else begin
      job_o.body[0] = in_byte_i;
    end
  end

  // Leading-blank mask and BCD increment of the line counter
  always_comb begin
    seen      = 1'b0;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      seen       = seen || (cnt_q[i] != 4'd0) || (i == 0);
      blank_o[i] = !seen;
      all_nines  = all_nines && (cnt_q[i] == 4'd9);
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry && cnt_q[i] == 4'd9) begin
        cnt_inc[i] = 4'd0;
      end else begin
        cnt_inc[i] = cnt_q[i] + {3'd0, carry};
        carry      = 1'b0;
      end
    end
  end

  assign bcd_o  = cnt_q;
  assign push_o = accept && !drop;

  // Next state
  always_comb begin
    prev_d = prev_q;
    cnt_d  = cnt_q;
    if (accept && !drop) begin
      prev_d = in_byte_i;
      if (has_num && !all_nines) begin
        cnt_d = cnt_inc;
      end
    end
  end

  // Hold line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= lnesc_pkg::CH_NL;
      run_q  <= 2'd0;
      cnt_q  <= (4 * NUMBER_DIGITS)'(1);
    end else begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      if (accept) begin
        run_q <= run_d;
      end
    end
  end

endmodule

// File: hdl/lnesc_fifo.sv
// Short job queue between front and back end, registers only.
// No package dependency.
module lnesc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_W-1:0]            wr_q, rd_q;
  logic [CNT_W-1:0]            cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/lnesc_back.sv
// Back end: expands the head job into output beats, one byte per cycle while the output is ready.
// Depends on lnesc_pkg.
module lnesc_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  lnesc_pkg::job_t                job_i,
  input  logic [NUMBER_DIGITS-1:0][3:0]  bcd_i,
  input  logic [NUMBER_DIGITS-1:0]       blank_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);

  localparam int POS_W = $clog2(NUMBER_DIGITS + 5);
  localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [POS_W-1:0] NUM_LEN = POS_W'(NUMBER_DIGITS + 1);
  localparam logic [POS_W-1:0] DIGITS  = POS_W'(NUMBER_DIGITS);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pre_len, body_pos, end_pos;
  logic [DIG_W-1:0] dig_idx;
  logic [7:0]       cur_byte, byte_q;
  logic             is_last, load, valid_q, last_q;

  assign pre_len  = job_i.has_num ? NUM_LEN : '0;
  assign body_pos = pos_q - pre_len;
  assign end_pos  = pre_len + POS_W'(job_i.body_len) - 1'b1;
  assign is_last  = (pos_q == end_pos);
  assign dig_idx  = DIG_W'(DIGITS - 1'b1 - pos_q);

  // Pick the byte at the current position
  always_comb begin
    if (job_i.has_num && pos_q < DIGITS) begin
      cur_byte = blank_i[dig_idx] ? lnesc_pkg::CH_SPACE
                                  : lnesc_pkg::CH_ZERO + {4'd0, bcd_i[dig_idx]};
    end else if (job_i.has_num && pos_q == DIGITS) begin
      cur_byte = lnesc_pkg::CH_TAB;
    end else begin
      cur_byte = job_i.body[body_pos[1:0]];
    end
  end

  assign load  = job_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && is_last;

  // Advance within the job
  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = is_last ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur_byte;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// File: hdl/lnesc_checker.sv
// Port-level checker for the line-number escaper, bound to the top level.
// No package dependency.
module lnesc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic [31:0] pend_q;
  logic        in_beat, last_beat;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign last_beat = m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o;

  // Count inputs whose final beat has not yet gone out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !last_beat && pend_q != '1) begin
      pend_q <= pend_q + 1'b1;
    end else if (last_beat && !in_beat && pend_q != '0) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // Never show a beat without an input still owing output
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != '0)
    else $error("output beat without a pending input");

  // The queue only fills through an accepted input
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("input ready fell without an accepted beat");

endmodule

bind text_stream_line_number_escaper_top lnesc_checker u_lnesc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

// File: test/tb_text_stream_line_number_escaper_top.sv
// Self-checking testbench for the line-number escaper top level.
// Depends on lnesc_pkg and text_stream_line_number_escaper_top; a scoreboard
// predicts the escaped byte stream for every input beat.
module tb_text_stream_line_number_escaper_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Line counter width of the default build
  localparam int LINE_DIGITS = 6;
  localparam int CLK_PERIOD  = 4;
  localparam int DRAIN_PAD   = 16;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_beat_t;

  // Predicts the output beats of the escaper and checks them in order
  class escaper_scoreboard;
    lnesc_pkg::cfg_t          modes;
    logic [7:0]               last_byte;
    logic [1:0]               blank_lines;
    logic [4*LINE_DIGITS-1:0] line_bcd;
    esc_beat_t                expected_q[$];
    int                       bad_beats;

    function new();
      modes       = '0;
      last_byte   = lnesc_pkg::CH_NL;
      blank_lines = '0;
      line_bcd    = 1;
      bad_beats   = 0;
    endfunction

    function void set_reg(lnesc_pkg::cfg_idx_e idx, logic val);
      case (idx)
        lnesc_pkg::CFG_NUMBER_NONBLANK:  modes.number_nonblank  = val;
        lnesc_pkg::CFG_NUMBER_ALL:       modes.number_all       = val;
        lnesc_pkg::CFG_SQUEEZE_BLANK:    modes.squeeze_blank    = val;
        lnesc_pkg::CFG_SHOW_ENDS:        modes.show_ends        = val;
        lnesc_pkg::CFG_SHOW_TABS:        modes.show_tabs        = val;
        lnesc_pkg::CFG_SHOW_NONPRINTING: modes.show_nonprinting = val;
        default: ;
      endcase
    endfunction

    function void expect_byte(logic [7:0] b);
      esc_beat_t e;
      e.data = b;
      e.last = 1'b0;
      expected_q.push_back(e);
    endfunction

    // Emit the padded line number and tab, then advance the BCD counter
    function void expect_line_number();
      logic       seen;
      logic       carry;
      logic [3:0] d;
      seen = 1'b0;
      for (int i = LINE_DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) seen = 1'b1;
        expect_byte(seen ? lnesc_pkg::CH_ZERO + {4'd0, d} : lnesc_pkg::CH_SPACE);
      end
      expect_byte(lnesc_pkg::CH_TAB);
      // hold the counter once it shows all nines
      if (line_bcd != {LINE_DIGITS{4'd9}}) begin
        carry = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
          d = line_bcd[4*i +: 4];
          if (carry) begin
            if (d == 4'd9) begin
              line_bcd[4*i +: 4] = 4'd0;
            end else begin
              line_bcd[4*i +: 4] = d + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    endfunction

    function void note_input(logic [7:0] c, logic sof);
      logic       at_start;
      logic [7:0] low;
      at_start = (last_byte == lnesc_pkg::CH_NL);
      if (sof) blank_lines = '0;

      // drop repeated empty lines; only the blank count changes
      if (modes.squeeze_blank && c == lnesc_pkg::CH_NL && at_start) begin
        if (blank_lines < 2'd2) blank_lines++;
        if (blank_lines > 2'd1) return;
      end else begin
        blank_lines = '0;
      end

      if (modes.number_nonblank) begin
        if (c != lnesc_pkg::CH_NL && at_start) expect_line_number();
      end else if (modes.number_all && at_start) begin
        expect_line_number();
      end

      if (modes.show_ends && c == lnesc_pkg::CH_NL) expect_byte(lnesc_pkg::CH_DOLLAR);

      if (modes.show_tabs && c == lnesc_pkg::CH_TAB) begin
        expect_byte(lnesc_pkg::CH_CARET);
        expect_byte(lnesc_pkg::CH_I);
      end else if (modes.show_nonprinting && c != lnesc_pkg::CH_TAB &&
                   c != lnesc_pkg::CH_NL) begin
        low = c;
        if (low >= 8'd128) begin
          expect_byte(lnesc_pkg::CH_M);
          expect_byte(lnesc_pkg::CH_DASH);
          low = low - 8'd128;
        end
        if (low < 8'd32) begin
          expect_byte(lnesc_pkg::CH_CARET);
          expect_byte(low + lnesc_pkg::CTRL_OFFSET);
        end else if (low == lnesc_pkg::CH_DEL) begin
          expect_byte(lnesc_pkg::CH_CARET);
          expect_byte(lnesc_pkg::CH_QMARK);
        end else begin
          expect_byte(low);
        end
      end else begin
        expect_byte(c);
      end

      last_byte = c;
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(logic [7:0] d, logic l);
      esc_beat_t e;
      if (expected_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected output beat: data=%02h last=%0b", d, l);
        return;
      end
      e = expected_q.pop_front();
      if (e.data !== d || e.last !== l) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("output mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                   e.data, e.last, d, l);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] in_byte
  logic       s_axis_tuser_i;   // [0] starts_file
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;   // last_of_run

  escaper_scoreboard sb;
  logic idle_on       = 1'b1;
  logic long_hold_req = 1'b0;
  int   cycle_count   = 0;
  int   items_sent    = 0;

  text_stream_line_number_escaper_top #(
    .NUMBER_DIGITS(LINE_DIGITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every output beat taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_beat(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin : sink
    int hold;
    hold = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 14) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input lnesc_pkg::cfg_idx_e idx, input logic val);
    logic [6:0] junk;
    junk = 7'($urandom);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= {junk, val};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_modes(input lnesc_pkg::cfg_t m);
    write_reg(lnesc_pkg::CFG_NUMBER_NONBLANK, m.number_nonblank);
    write_reg(lnesc_pkg::CFG_NUMBER_ALL, m.number_all);
    write_reg(lnesc_pkg::CFG_SQUEEZE_BLANK, m.squeeze_blank);
    write_reg(lnesc_pkg::CFG_SHOW_ENDS, m.show_ends);
    write_reg(lnesc_pkg::CFG_SHOW_TABS, m.show_tabs);
    write_reg(lnesc_pkg::CFG_SHOW_NONPRINTING, m.show_nonprinting);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one input beat, with an optional idle burst in front of it
  task automatic send_beat(input logic [7:0] b, input logic sof);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= sof;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(b, sof);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Wait for every predicted beat, then let squeezed lines settle
  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
      5:             return lnesc_pkg::CH_TAB;
      6:             return 8'($urandom_range(0, 31));
      7:             return lnesc_pkg::CH_DEL;
      8:             return 8'($urandom_range(128, 255));
      default:       return lnesc_pkg::CH_NL;
    endcase
  endfunction

  // Short lines keep the counter moving; some start a new file
  task automatic send_random_line();
    int   len;
    logic new_file;
    len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    new_file = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++)
      send_beat(random_text_byte(), (i == 0) ? new_file : ($urandom_range(0, 39) == 0));
    send_beat(lnesc_pkg::CH_NL, (len == 0) ? new_file : 1'b0);
  endtask

  initial begin : stimulus
    lnesc_pkg::cfg_t m;
    logic [5:0]      r;
    int              phase_start;
    sb = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = lnesc_pkg::CFG_NUMBER_NONBLANK;
    cfg_data_i      = 8'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'd0;
    s_axis_tuser_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Numbering, squeezing and every escape form
    m = '0;
    m.number_all = 1'b1;
    m.squeeze_blank = 1'b1;
    m.show_ends = 1'b1;
    m.show_tabs = 1'b1;
    m.show_nonprinting = 1'b1;
    apply_modes(m);
    send_beat("a", 1'b1);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b1);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(lnesc_pkg::CH_TAB, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h1F, 1'b0);
    send_beat(lnesc_pkg::CH_DEL, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hA0, 1'b0);
    send_beat(8'hFE, 1'b0);
    send_beat(lnesc_pkg::CH_SPACE, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    stop_sending();
    wait_idle();

    // Non-blank numbering wins; a raw tab passes even with escaping on
    m = '0;
    m.number_nonblank = 1'b1;
    m.number_all = 1'b1;
    m.show_nonprinting = 1'b1;
    apply_modes(m);
    send_beat(lnesc_pkg::CH_TAB, 1'b0);
    send_beat("x", 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(lnesc_pkg::CH_NL, 1'b0);
    stop_sending();
    wait_idle();

    // Random phases: all off, all on, then mixed modes; the last runs flat out
    for (int p = 0; p < 7; p++) begin
      if (p == 0) begin
        m = '0;
      end else if (p == 1) begin
        m = '1;
      end else begin
        r = $urandom_range(0, 63);
        m = r;
        if ($urandom_range(0, 3) != 0) m.number_all = 1'b1;
      end
      apply_modes(m);
      idle_on = (p != 6);
      if (p == 2) long_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_line();
      stop_sending();
      wait_idle();
    end

    if (sb.bad_beats == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
